[src/assert_macros.svh]
// Assertion macros shared by the cache model RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/salc_pkg.sv]
// Shared types and constants of the set-associative LRU cache model.
package salc_pkg;

    localparam int ADDR_W = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_addr;
        logic mul_tag;
        logic back_tag;
        logic split;
        logic mul_set;
        logic rd_row;
        logic update;
        logic clr_wr;
        logic push;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } t_dp_status;

endpackage

[src/salc_if.sv]
// Valid/ready channel interfaces for addresses in and hit flags out.
interface salc_in_if import salc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] addr;

    modport source (output valid, output addr, input ready);
    modport sink (input valid, input addr, output ready);
endinterface

interface salc_out_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, output hit, input ready);
    modport sink (input valid, input hit, output ready);
endinterface

[src/salc_ctrl.sv]
// Controller state machine that sequences clear, split, lookup and result transfer.
`include "assert_macros.svh"

module salc_ctrl import salc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_MUL_TAG  = 4'd2;
    localparam logic [3:0] S_BACK_TAG = 4'd3;
    localparam logic [3:0] S_SPLIT    = 4'd4;
    localparam logic [3:0] S_MUL_SET  = 4'd5;
    localparam logic [3:0] S_READ     = 4'd6;
    localparam logic [3:0] S_LOOKUP   = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_addr = 1'b1;
                    n_state         = S_MUL_TAG;
                end
            end
            S_MUL_TAG: begin
                o_cmd.mul_tag = 1'b1;
                n_state       = S_BACK_TAG;
            end
            S_BACK_TAG: begin
                o_cmd.back_tag = 1'b1;
                n_state        = S_SPLIT;
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = S_MUL_SET;
            end
            S_MUL_SET: begin
                o_cmd.mul_set = 1'b1;
                n_state       = S_READ;
            end
            S_READ: begin
                o_cmd.rd_row = 1'b1;
                n_state      = S_LOOKUP;
            end
            S_LOOKUP: begin
                o_cmd.update = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    `ASSERT_NEXT(a_accept_starts_div, i_in_valid && o_in_ready,
        r_state == S_MUL_TAG, "accepted address did not start the tag split")
    `ASSERT_NOW(a_push_into_free, o_cmd.push, !i_status.out_busy,
        "result pushed while the output register is still full")

endmodule

[src/salc_datapath.sv]
// Datapath: reciprocal address split, set memory, tag compare, LRU update and output register.
`include "assert_macros.svh"

module salc_datapath import salc_pkg::*; #(
    parameter int NUM_SETS    = 512,
    parameter int WAYS        = 8,
    parameter int BLOCK_BYTES = 64,
    parameter int ADDR_BITS   = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    output t_dp_status        o_status,
    input  logic [ADDR_W-1:0] i_addr,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_out_hit
);

    localparam longint unsigned ADDR_MAX =
        (ADDR_BITS >= ADDR_W) ? ((64'd1 << ADDR_W) - 64'd1) : ((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'(ADDR_MAX);
    localparam longint unsigned BLOCK_L   = BLOCK_BYTES;
    localparam longint unsigned LINE_SPAN = BLOCK_L * longint'(NUM_SETS);
    localparam longint unsigned TAG_MAX   = ADDR_MAX / LINE_SPAN;
    localparam int TAG_W = (TAG_MAX == 0) ? 1 : $clog2(TAG_MAX + 1);
    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W = $clog2(WAYS + 1);
    localparam int TAG_OFS = WAYS;
    localparam int AGE_OFS = WAYS + WAYS * TAG_W;
    localparam int ROW_W   = WAYS * (1 + TAG_W + WAY_W);

    // With k = ADDR_W + ceil(log2 d) and m = ceil(2^k / d), (x * m) >> k equals x / d
    // exactly for every ADDR_W-bit x.
    localparam int RECIP_W = ADDR_W + 1;
    localparam int PROD_W  = ADDR_W + RECIP_W;
    localparam int K_SPAN  = ADDR_W + $clog2(LINE_SPAN);
    localparam int K_BLOCK = ADDR_W + $clog2(BLOCK_L);
    localparam longint unsigned RECIP_SPAN_L =
        ((64'd1 << K_SPAN) + LINE_SPAN - 64'd1) / LINE_SPAN;
    localparam longint unsigned RECIP_BLOCK_L =
        ((64'd1 << K_BLOCK) + BLOCK_L - 64'd1) / BLOCK_L;
    localparam logic [RECIP_W-1:0] RECIP_SPAN  = RECIP_W'(RECIP_SPAN_L);
    localparam logic [RECIP_W-1:0] RECIP_BLOCK = RECIP_W'(RECIP_BLOCK_L);
    localparam logic [ADDR_W-1:0]  SPAN_C      = ADDR_W'(LINE_SPAN);

    localparam logic [WAY_W-1:0] AGE_OLDEST   = WAY_W'(WAYS - 1);
    localparam logic [SET_W-1:0] SET_LAST     = SET_W'(NUM_SETS - 1);

    // One row per set: valid bits, then tags, then ages.
    logic [ROW_W-1:0] mem [NUM_SETS];

    logic [ADDR_W-1:0] r_num;
    logic [PROD_W-1:0] r_prod;
    logic [ADDR_W-1:0] r_back;
    logic [TAG_W-1:0]  r_tag;
    logic [SET_W-1:0]  r_set;
    logic [SET_W-1:0]  r_clr_addr;
    logic [ROW_W-1:0]  r_row;
    logic              r_res_hit;
    logic              r_out_valid;
    logic              r_out_hit;

    logic [RECIP_W-1:0] recip_sel;
    logic [ADDR_W-1:0]  tag_quo;
    logic [SET_W-1:0]   set_idx;

    logic [WAYS-1:0]   row_valid;
    logic [TAG_W-1:0]  row_tag [WAYS];
    logic [WAY_W-1:0]  row_age [WAYS];
    logic [WAYS-1:0]   hit_vec;
    logic [WAYS-1:0]   old_vec;
    logic              hit;
    logic              full;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  inv_way;
    logic [WAY_W-1:0]  old_way;
    logic [WAY_W-1:0]  used_way;
    logic [AGE_W-1:0]  old_age;
    logic [ROW_W-1:0]  new_row;

    logic              wr_en;
    logic [SET_W-1:0]  wr_addr;
    logic [ROW_W-1:0]  wr_data;

    // One shared multiplier serves both divisions; the shifts are plain wiring.
    assign recip_sel = i_cmd.mul_set ? RECIP_BLOCK : RECIP_SPAN;
    assign tag_quo   = ADDR_W'(r_prod >> K_SPAN);
    assign set_idx   = SET_W'(r_prod >> K_BLOCK);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_addr) begin
            r_num <= i_addr & ADDR_MASK;
        end else if (i_cmd.split) begin
            // What is left below the tag is set * BLOCK_BYTES + offset.
            r_num <= r_num - r_back;
        end
        if (i_cmd.mul_tag || i_cmd.mul_set) begin
            r_prod <= PROD_W'(r_num) * PROD_W'(recip_sel);
        end
        if (i_cmd.back_tag) begin
            r_tag  <= tag_quo[TAG_W-1:0];
            r_back <= tag_quo * SPAN_C;
        end
        if (i_cmd.rd_row) begin
            r_set <= set_idx;
        end
        if (i_cmd.update) begin
            r_res_hit <= hit;
        end
    end

    // Clear pointer and output register are control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_hit <= r_res_hit;
        end
    end

    assign wr_en   = i_cmd.clr_wr | i_cmd.update;
    assign wr_addr = i_cmd.clr_wr ? r_clr_addr : r_set;
    assign wr_data = i_cmd.clr_wr ? '0 : new_row;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_row) begin
            r_row <= mem[set_idx];
        end
    end

    always_comb begin
        row_valid = r_row[WAYS-1:0];
        for (int w = 0; w < WAYS; w++) begin
            row_tag[w] = r_row[TAG_OFS + w * TAG_W +: TAG_W];
            row_age[w] = r_row[AGE_OFS + w * WAY_W +: WAY_W];
            hit_vec[w] = row_valid[w] && (row_tag[w] == r_tag);
            old_vec[w] = (row_age[w] == AGE_OLDEST);
        end
        hit  = |hit_vec;
        full = &row_valid;
    end

    // Lowest-numbered way wins in each search.
    always_comb begin
        hit_way = '0;
        inv_way = '0;
        old_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
            if (!row_valid[w]) begin
                inv_way = WAY_W'(w);
            end
            if (old_vec[w]) begin
                old_way = WAY_W'(w);
            end
        end
    end

    // Valid ages are distinct ranks, so a full set has exactly one way of the oldest rank.
    always_comb begin
        priority if (hit) begin
            used_way = hit_way;
            old_age  = AGE_W'(row_age[hit_way]);
        end else if (full) begin
            used_way = old_way;
            old_age  = AGE_W'(AGE_OLDEST);
        end else begin
            used_way = inv_way;
            old_age  = AGE_W'(WAYS);
        end
    end

    always_comb begin
        new_row = r_row;
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == used_way) begin
                new_row[w]                            = 1'b1;
                new_row[TAG_OFS + w * TAG_W +: TAG_W] = r_tag;
                new_row[AGE_OFS + w * WAY_W +: WAY_W] = '0;
            end else if (row_valid[w] && (AGE_W'(row_age[w]) < old_age)) begin
                new_row[AGE_OFS + w * WAY_W +: WAY_W] = row_age[w] + 1'b1;
            end
        end
    end

    assign o_status.clr_last = (r_clr_addr == SET_LAST);
    assign o_status.out_busy = r_out_valid;
    assign o_out_valid       = r_out_valid;
    assign o_out_hit         = r_out_hit;

    `ASSERT_NOW(a_single_hit, i_cmd.update, $onehot0(hit_vec),
        "more than one way of a set matched the tag")
    `ASSERT_NOW(a_valid_prefix, i_cmd.update, (row_valid & (row_valid + 1'b1)) == '0,
        "valid ways of a set are not filled from way zero up")
    `ASSERT_NOW(a_one_oldest, i_cmd.update && full, $onehot(old_vec),
        "a full set does not hold exactly one way of the oldest rank")

endmodule

[src/set_assoc_lru_cache_hit_model.sv]
// Top level of the set-associative LRU cache hit/miss model.
//
//   Channel   Dir   Payload      Meaning
//   i_in      in    addr[31:0]   byte address of one access
//   o_out     out   hit          1 on hit, 0 on miss and fill
//
// A new address is not taken until the previous one is through: a reciprocal multiply
// yields the tag, a back multiply and a subtract leave the part below the tag, a second
// reciprocal multiply yields the set, then the set row is read, then compared and written
// back, then the output register is loaded once it is free. After reset a clearing pass
// zeroes all NUM_SETS rows of the set memory before the first address is taken. The output
// register holds a result while o_out is stalled; a second result waits in the datapath.
module set_assoc_lru_cache_hit_model import salc_pkg::*; #(
    parameter int NUM_SETS    = 512,
    parameter int WAYS        = 8,
    parameter int BLOCK_BYTES = 64,
    parameter int ADDR_BITS   = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    salc_in_if.sink           i_in,
    salc_out_if.source        o_out
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;
    logic       w_out_valid;
    logic       w_out_hit;

    salc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    salc_datapath #(
        .NUM_SETS    (NUM_SETS),
        .WAYS        (WAYS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_addr      (i_in.addr),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_out_hit   (w_out_hit)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.hit   = w_out_hit;

endmodule
